// ----- rtl/kmdc_pkg.sv -----
// shared types and constants for the key matrix debounce with fn chord flags
// no dependencies
`timescale 1ns / 1ps

package kmdc_pkg;

  localparam int ROWS        = 16;
  localparam int COLS        = 8;
  localparam int DIRECT_KEYS = 2;

  localparam int MATRIX_KEYS = ROWS * COLS;
  localparam int KEY_TOTAL   = MATRIX_KEYS + DIRECT_KEYS;
  localparam int FN_KEY      = MATRIX_KEYS;
  localparam int CHORD_COUNT = 4;
  localparam int KEY_AW      = $clog2(KEY_TOTAL);

  localparam int KEY_W   = 8;
  localparam int DEB_W   = 4;
  localparam int COUNT_W = 4;

  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(4);

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             level;
  } kmdc_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]       changed_key;
    logic                   pressed;
    logic [CHORD_COUNT-1:0] chord_new;
    logic [CHORD_COUNT-1:0] chord_held;
  } kmdc_out_t;

  typedef struct packed {
    logic               stable;
    logic               cand;
    logic [COUNT_W-1:0] count;
  } kmdc_entry_t;

  // number key of chord i: column one of row i
  function automatic logic [KEY_AW-1:0] chord_key(input int i);
    return KEY_AW'(i * COLS + 1);
  endfunction

endpackage

// ----- rtl/key_matrix_debounce_chord.sv -----
// key matrix debounce with fn chord flags, top level
// per-key state in a two-port memory with per-entry valid flops; uses kmdc_pkg
//
//  channel  ports                          payload
//  in       in_valid  in_ready  in_data    kmdc_in_t, one key sample
//  out      out_valid out_ready out_data   kmdc_out_t, one stable level change
//  cfg      cfg_valid cfg_ready cfg_data   debounce count, 4 bits
//
// one sample per cycle sustained while the result is not stalled; a result is valid once its sample
// has passed the input register (memory read alongside it) and then the update into the result register
// back-to-back samples of the same key are forwarded around the memory write
// no clearing pass: valid flops are cleared at reset, an entry never written reads as zero
// a stalled result holds the update stage; samples are still taken while the stage can move
`timescale 1ns / 1ps

module key_matrix_debounce_chord (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmdc_pkg::kmdc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kmdc_pkg::kmdc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  import kmdc_pkg::*;

  logic [DEB_W-1:0]       deb_r;
  logic                   s1_valid_r;
  logic [KEY_AW-1:0]      s1_key_r;
  logic                   s1_lvl_r;
  kmdc_entry_t            rd_r;
  logic                   rd_vld_r;
  kmdc_entry_t            mem [KEY_TOTAL];
  logic [KEY_TOTAL-1:0]   vld_r;
  logic [CHORD_COUNT-1:0] chord_lvl_r;
  logic                   fn_lvl_r;
  logic [CHORD_COUNT-1:0] reported_r;
  logic                   out_valid_r;
  kmdc_out_t              out_r;

  logic                   adv;
  logic                   in_fire;
  logic                   in_inrange;
  logic [KEY_AW-1:0]      in_key;
  logic                   bypass;
  kmdc_entry_t            cur;
  kmdc_entry_t            wdata;
  logic [DEB_W-1:0]       thr;
  logic                   emit;
  logic [CHORD_COUNT-1:0] chord_nxt;
  logic                   fn_nxt;
  logic [CHORD_COUNT-1:0] held;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign in_fire   = in_valid && in_ready;
  assign in_key    = KEY_AW'(in_data.key_index);
  assign in_inrange = 32'(in_data.key_index) < KEY_TOTAL;
  assign bypass    = s1_valid_r && adv && (s1_key_r == in_key);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // update stage
  always_comb begin
    cur   = rd_vld_r ? rd_r : '0;
    thr   = (deb_r == '0) ? DEB_W'(1) : deb_r;
    wdata = cur;
    emit  = 1'b0;
    if (s1_lvl_r != cur.cand) begin
      wdata.cand  = s1_lvl_r;
      wdata.count = COUNT_W'(1);
    end else begin
      wdata.count = (cur.count < thr) ? cur.count + COUNT_W'(1) : thr;
      if (wdata.count == thr && cur.stable != s1_lvl_r) begin
        wdata.stable = s1_lvl_r;
        emit         = 1'b1;
      end
    end
    chord_nxt = chord_lvl_r;
    for (int i = 0; i < CHORD_COUNT; i++) begin
      if (s1_key_r == chord_key(i)) begin
        chord_nxt[i] = wdata.stable;
      end
    end
    fn_nxt = (s1_key_r == KEY_AW'(FN_KEY)) ? wdata.stable : fn_lvl_r;
    held   = fn_nxt ? chord_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      mem[s1_key_r] <= wdata;
    end
    if (in_fire) begin
      rd_r <= bypass ? wdata : mem[in_key];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (s1_valid_r && adv) begin
        vld_r[s1_key_r] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_r <= bypass || vld_r[in_key];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r       <= DEB_RESET;
      s1_valid_r  <= 1'b0;
      chord_lvl_r <= '0;
      fn_lvl_r    <= 1'b0;
      reported_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        deb_r <= cfg_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_fire && in_inrange;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r && emit;
      end
      if (s1_valid_r && adv) begin
        chord_lvl_r <= chord_nxt;
        fn_lvl_r    <= fn_nxt;
        if (emit) begin
          reported_r <= held;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key_r <= in_key;
      s1_lvl_r <= in_data.level;
    end
    if (s1_valid_r && adv && emit) begin
      out_r.changed_key <= KEY_W'(s1_key_r);
      out_r.pressed     <= s1_lvl_r;
      out_r.chord_new   <= held & ~reported_r;
      out_r.chord_held  <= held;
    end
  end

endmodule

// ----- rtl/kmdc_checker.sv -----
// port-level checks for key_matrix_debounce_chord, bound to the top level
// uses kmdc_pkg
`timescale 1ns / 1ps

module kmdc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input kmdc_pkg::kmdc_out_t out_data
);
  import kmdc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a new result follows a sample transfer that has passed the input register and then the result register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a sample transfer");

  a_chord_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.chord_new & ~out_data.chord_held) == '0)
    else $error("new chord flag not held");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.changed_key) < KEY_TOTAL)
    else $error("result key out of range");

endmodule

bind key_matrix_debounce_chord kmdc_checker u_kmdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
